>>> design/world_to_screen_projection_assert.svh
// Assertion macros for the world-to-screen projection block.
// Used by the top level; expects clk and rst in scope.
`ifndef WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH

// same-cycle implication
`define WTSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WTSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/wtsp_pkg.sv
// Shared types and constants for the world-to-screen projection block.
// No dependencies.
`default_nettype none

package wtsp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // quotient magnitude saturates at 2^QBITS
  localparam int QBITS         = 46;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0_01 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_23 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_01 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_23 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_01 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_23 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE    = 4'd7;

  localparam logic [CFG_DATA_W-1:0] RST_ROW0_01 = 64'd65536;
  localparam logic [CFG_DATA_W-1:0] RST_ROW0_23 = 64'd0;
  localparam logic [CFG_DATA_W-1:0] RST_ROW1_01 = 64'd281474976710656;
  localparam logic [CFG_DATA_W-1:0] RST_ROW1_23 = 64'd0;
  localparam logic [CFG_DATA_W-1:0] RST_ROW3_01 = 64'd0;
  localparam logic [CFG_DATA_W-1:0] RST_ROW3_23 = 64'd281474976710656;
  localparam logic [31:0]           RST_ORIGIN  = 32'd0;
  localparam logic [31:0]           RST_SIZE    = 32'd31458560;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_beat_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] m00, m01, m02, m03;
    logic signed [31:0] m10, m11, m12, m13;
    logic signed [31:0] m30, m31, m32, m33;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [15:0]        width;
    logic [15:0]        height;
  } coef_t;

  // travels with each beat down the pipe
  typedef struct packed {
    logic valid;
    logic visible;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } ctl_t;

endpackage

`default_nettype wire

>>> design/wtsp_cfg.sv
// Configuration register file: matrix rows 0, 1, 3, screen origin and size.
// Depends on wtsp_pkg.
`default_nettype none

module wtsp_cfg import wtsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output coef_t                 coef
);

  logic [CFG_DATA_W-1:0] row0_01, row0_23, row1_01, row1_23, row3_01, row3_23;
  logic [31:0]           origin, size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row0_01 <= RST_ROW0_01;
      row0_23 <= RST_ROW0_23;
      row1_01 <= RST_ROW1_01;
      row1_23 <= RST_ROW1_23;
      row3_01 <= RST_ROW3_01;
      row3_23 <= RST_ROW3_23;
      origin  <= RST_ORIGIN;
      size    <= RST_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW0_01: row0_01 <= cfg_data;
        REG_ROW0_23: row0_23 <= cfg_data;
        REG_ROW1_01: row1_01 <= cfg_data;
        REG_ROW1_23: row1_23 <= cfg_data;
        REG_ROW3_01: row3_01 <= cfg_data;
        REG_ROW3_23: row3_23 <= cfg_data;
        REG_ORIGIN:  origin  <= cfg_data[31:0];
        REG_SIZE:    size    <= cfg_data[31:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    coef.m00    = row0_01[31:0];
    coef.m01    = row0_01[63:32];
    coef.m02    = row0_23[31:0];
    coef.m03    = row0_23[63:32];
    coef.m10    = row1_01[31:0];
    coef.m11    = row1_01[63:32];
    coef.m12    = row1_23[31:0];
    coef.m13    = row1_23[63:32];
    coef.m30    = row3_01[31:0];
    coef.m31    = row3_01[63:32];
    coef.m32    = row3_23[31:0];
    coef.m33    = row3_23[63:32];
    coef.left   = origin[15:0];
    coef.top    = origin[31:16];
    coef.width  = size[15:0];
    coef.height = size[31:16];
  end

endmodule

`default_nettype wire

>>> design/wtsp_clip.sv
// Clip-space transform: products, row sums, visibility test and divider setup.
// Three register stages. Depends on wtsp_pkg.
`default_nettype none

module wtsp_clip import wtsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int CW = 65 - FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  in_beat_t      in_data,
  input  coef_t         coef,
  output ctl_t          ctl,
  output logic [CW-1:0] mag_x,
  output logic [CW-1:0] mag_y,
  output logic [CW-1:0] div_w
);

  localparam int K  = QBITS - FRAC_BITS;
  localparam int VW = CW + 8;
  localparam logic signed [VW-1:0] VIS_TH = VW'(1) <<< FRAC_BITS;

  logic signed [63:0]   prod [9];
  logic                 v1, v2;
  logic signed [CW-1:0] cx, cy, cw;
  logic signed [CW-1:0] cx_next, cy_next, cw_next;
  logic signed [VW-1:0] w_ext, w100;
  logic                 vis_next, negx_next, negy_next;
  logic [CW-1:0]        ax_next, ay_next;

  function automatic logic signed [CW-1:0] fsh(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p >>> FRAC_BITS;
    return t[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      prod[0] <= coef.m00 * in_data.world_x;
      prod[1] <= coef.m01 * in_data.world_y;
      prod[2] <= coef.m02 * in_data.world_z;
      prod[3] <= coef.m10 * in_data.world_x;
      prod[4] <= coef.m11 * in_data.world_y;
      prod[5] <= coef.m12 * in_data.world_z;
      prod[6] <= coef.m30 * in_data.world_x;
      prod[7] <= coef.m31 * in_data.world_y;
      prod[8] <= coef.m32 * in_data.world_z;
    end
  end

  always_comb begin
    cx_next = CW'(coef.m03) + fsh(prod[0]) + fsh(prod[1]) + fsh(prod[2]);
    cy_next = CW'(coef.m13) + fsh(prod[3]) + fsh(prod[4]) + fsh(prod[5]);
    cw_next = CW'(coef.m33) + fsh(prod[6]) + fsh(prod[7]) + fsh(prod[8]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      cx <= cx_next;
      cy <= cy_next;
      cw <= cw_next;
    end
  end

  // visible iff 100*w >= 1.0
  always_comb begin
    w_ext     = VW'(cw);
    w100      = (w_ext <<< 6) + (w_ext <<< 5) + (w_ext <<< 2);
    vis_next  = (w100 >= VIS_TH);
    negx_next = cx[CW-1];
    negy_next = cy[CW-1];
    ax_next   = negx_next ? CW'(-cx) : CW'(cx);
    ay_next   = negy_next ? CW'(-cy) : CW'(cy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (adv) begin
      ctl.valid <= v2;
    end
    if (adv) begin
      ctl.visible <= vis_next;
      ctl.neg_x   <= negx_next;
      ctl.neg_y   <= negy_next;
      // integer part of |n|/w already at or beyond 2^K
      ctl.ovf_x   <= (ax_next >> K) >= CW'(cw);
      ctl.ovf_y   <= (ay_next >> K) >= CW'(cw);
      mag_x       <= ax_next;
      mag_y       <= ay_next;
      div_w       <= CW'(cw);
    end
  end

endmodule

`default_nettype wire

>>> design/wtsp_div.sv
// Pipelined restoring divider, two lanes (x and y) sharing the divisor.
// One quotient bit per stage. Depends on wtsp_pkg.
`default_nettype none

module wtsp_div import wtsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int CW = 65 - FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  ctl_t           ctl_in,
  input  logic [CW-1:0]  mag_x,
  input  logic [CW-1:0]  mag_y,
  input  logic [CW-1:0]  div_w,
  output ctl_t           ctl_out,
  output logic [QBITS:0] quo_x,
  output logic [QBITS:0] quo_y
);

  localparam int K = QBITS - FRAC_BITS;

  ctl_t             cs   [QBITS+1];
  logic [CW-1:0]    bw   [QBITS+1];
  logic [CW-1:0]    rem  [2][QBITS+1];
  logic [QBITS-1:0] lo   [2][QBITS+1];
  logic [QBITS-1:0] quo  [2][QBITS+1];
  logic [CW-1:0]    mag  [2];

  assign mag[0] = mag_x;
  assign mag[1] = mag_y;

  // stage 0: remainder starts at the dividend bits above 2^QBITS
  always_ff @(posedge clk) begin
    if (rst) begin
      cs[0].valid <= 1'b0;
    end else if (adv) begin
      cs[0] <= ctl_in;
    end
    if (adv) begin
      bw[0] <= div_w;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane_init
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[l][0] <= mag[l] >> K;
        lo[l][0]  <= {mag[l][K-1:0], {FRAC_BITS{1'b0}}};
        quo[l][0] <= '0;
      end
    end
  end

  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        cs[s+1].valid <= 1'b0;
      end else if (adv) begin
        cs[s+1] <= cs[s];
      end
      if (adv) begin
        bw[s+1] <= bw[s];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [CW:0] trial;
      logic        ge;
      always_comb begin
        trial = {rem[l][s], lo[l][s][QBITS-1]};
        ge    = trial >= {1'b0, bw[s]};
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[l][s+1] <= ge ? CW'(trial - {1'b0, bw[s]}) : trial[CW-1:0];
          lo[l][s+1]  <= lo[l][s] << 1;
          quo[l][s+1] <= {quo[l][s][QBITS-2:0], ge};
        end
      end
    end
  end

  assign ctl_out = cs[QBITS];
  assign quo_x   = cs[QBITS].ovf_x ? (QBITS+1)'(1) << QBITS : {1'b0, quo[0][QBITS]};
  assign quo_y   = cs[QBITS].ovf_y ? (QBITS+1)'(1) << QBITS : {1'b0, quo[1][QBITS]};

endmodule

`default_nettype wire

>>> design/wtsp_pixel.sv
// Viewport mapping: sign, scale by half the screen size, add origin, saturate.
// Three register stages, the last is the output register. Depends on wtsp_pkg.
`default_nettype none

module wtsp_pixel import wtsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  ctl_t           ctl_in,
  input  logic [QBITS:0] quo_x,
  input  logic [QBITS:0] quo_y,
  input  coef_t          coef,
  output logic           out_valid,
  output out_beat_t      out_data
);

  localparam int TW = QBITS + 3;
  localparam int PW = TW + 17;
  localparam logic signed [TW-1:0] ONE  = TW'(1) <<< FRAC_BITS;
  localparam logic signed [PW-1:0] SMAX = PW'(32'sh7fffffff);
  localparam logic signed [PW-1:0] SMIN = -PW'(33'sh080000000);

  logic                 va, vb, vis_a, vis_b;
  logic signed [TW-1:0] qx_s, qy_s, tx, ty;
  logic signed [PW-1:0] px, py, sx, sy;

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic signed [31:0] r;
    if (v > SMAX) begin
      r = 32'sh7fffffff;
    end else if (v < SMIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    qx_s = $signed({2'b00, quo_x});
    qy_s = $signed({2'b00, quo_y});
  end

  // stage A: 1 + x/w and 1 - y/w
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= ctl_in.valid;
    end
    if (adv) begin
      vis_a <= ctl_in.visible;
      tx    <= ONE + (ctl_in.neg_x ? -qx_s : qx_s);
      ty    <= ONE + (ctl_in.neg_y ? qy_s : -qy_s);
    end
  end

  // stage B: times screen size
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
    if (adv) begin
      vis_b <= vis_a;
      px    <= PW'($signed({1'b0, coef.width})) * PW'(tx);
      py    <= PW'($signed({1'b0, coef.height})) * PW'(ty);
    end
  end

  always_comb begin
    sx = (px >>> 1) + (PW'(coef.left) <<< FRAC_BITS);
    sy = (py >>> 1) + (PW'(coef.top) <<< FRAC_BITS);
  end

  // stage C: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vb;
    end
    if (adv) begin
      out_data.visible  <= vis_b;
      out_data.screen_x <= vis_b ? sat32(sx) : '0;
      out_data.screen_y <= vis_b ? sat32(sy) : '0;
    end
  end

endmodule

`default_nettype wire

>>> design/world_to_screen_projection.sv
// World-to-screen perspective projection.
// Input beat: world_x/y/z, signed fixed point with FRAC_BITS fraction bits.
// Output beat: visible flag and screen_x/y pixels in the same format,
// saturated to 32 bits; zero coordinates when clip w is below 0.01.
// Config channel: cfg_index selects one of eight registers (matrix rows
// 0, 1, 3 packed two coefficients each, screen origin, screen size);
// writes to unmapped indices are dropped. cfg_ready is always high.
// Throughput: one beat per clock while out_valid is low or out_ready is high.
// Pipeline: 3 transform stages, 47 divider stages (one setup stage, then
// one quotient bit per stage), 3 viewport stages. The divider depth
// dominates the latency.
// Reset restores the default matrix and a 1280x480 screen at the origin,
// and empties the pipe. When out_ready is low with a beat waiting, the whole
// pipe holds and in_ready drops in the same cycle; nothing is lost.
// Depends on wtsp_pkg, wtsp_cfg, wtsp_clip, wtsp_div, wtsp_pixel.
`default_nettype none
`include "world_to_screen_projection_assert.svh"

module world_to_screen_projection import wtsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = 65 - FRAC_BITS;

  coef_t          coef;
  logic           adv;
  ctl_t           ctl_clip, ctl_div;
  logic [CW-1:0]  mag_x, mag_y, div_w;
  logic [QBITS:0] quo_x, quo_y;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  wtsp_cfg u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .coef
  );

  wtsp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
    .clk, .rst, .adv,
    .in_valid (in_valid),
    .in_data,
    .coef,
    .ctl      (ctl_clip),
    .mag_x, .mag_y, .div_w
  );

  wtsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst, .adv,
    .ctl_in  (ctl_clip),
    .mag_x, .mag_y, .div_w,
    .ctl_out (ctl_div),
    .quo_x, .quo_y
  );

  wtsp_pixel #(.FRAC_BITS(FRAC_BITS)) u_pixel (
    .clk, .rst, .adv,
    .ctl_in (ctl_div),
    .quo_x, .quo_y,
    .coef,
    .out_valid, .out_data
  );

  `WTSP_ASSERT_IMPL(a_hidden_zero, out_valid && !out_data.visible, out_data.screen_x == 0 && out_data.screen_y == 0, "hidden point with nonzero coordinates")
  `WTSP_ASSERT_NEXT(a_stall_holds_output, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed while stalled")
  `WTSP_ASSERT_IMPL(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "input taken while output stalled")
  `WTSP_ASSERT_IMPL(a_drain_ready, !out_valid, in_ready, "input blocked with empty output")

endmodule

`default_nettype wire

>>> verif/wtsp_checker.sv
// Scoreboard for world_to_screen_projection: watches input, output and config
// channels, predicts each projected point and compares it with the output beat.
// Depends on wtsp_pkg.
module wtsp_checker import wtsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_beat_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_beat_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    n_visible,
  output int                    n_hidden
);
  localparam int FB = FRAC_BITS_DEF;
  localparam logic signed [127:0] QLIM = 128'sd1 <<< QBITS;

  logic [63:0] shadow_regs [8];
  out_beat_t   expected_pts [$];

  function automatic longint row_sum(int r, longint x, longint y, longint z);
    logic [63:0] a, b;
    longint acc;
    a = shadow_regs[r];
    b = shadow_regs[r+1];
    acc = longint'($signed(b[63:32]));
    acc += (longint'($signed(a[31:0])) * x) >>> FB;
    acc += (longint'($signed(a[63:32])) * y) >>> FB;
    acc += (longint'($signed(b[31:0])) * z) >>> FB;
    return acc;
  endfunction

  // n / w, magnitude truncated, clamped to 2^QBITS
  function automatic logic signed [127:0] norm_div(longint n, longint w);
    logic [127:0] mag, den, q;
    mag = (n < 0) ? 128'(-n) : 128'(n);
    den = 128'(w);
    if (mag / den >= (128'd1 << (QBITS - FB))) q = QLIM;
    else begin
      q = (mag << FB) / den;
      if (q > QLIM) q = QLIM;
    end
    return (n < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [31:0] to_px(logic [15:0] size, logic signed [127:0] q,
                                        logic signed [15:0] org);
    logic signed [127:0] v, sz, og;
    sz = $signed({112'd0, size});
    og = org;
    v = (sz * ((128'sd1 <<< FB) + q)) >>> 1;
    v = v + (og <<< FB);
    if (v > 128'sd2147483647) v = 128'sd2147483647;
    if (v < -128'sd2147483648) v = -128'sd2147483648;
    return v[31:0];
  endfunction

  function automatic out_beat_t project(in_beat_t p);
    longint x, y, z, cx, cy, cw;
    logic [31:0] org, sz;
    out_beat_t r;
    x = p.world_x;
    y = p.world_y;
    z = p.world_z;
    cx = row_sum(0, x, y, z);
    cy = row_sum(2, x, y, z);
    cw = row_sum(4, x, y, z);
    org = shadow_regs[REG_ORIGIN][31:0];
    sz = shadow_regs[REG_SIZE][31:0];
    r = '0;
    if (cw * 100 >= (64'sd1 <<< FB)) begin
      r.visible = 1'b1;
      r.screen_x = to_px(sz[15:0], norm_div(cx, cw), org[15:0]);
      r.screen_y = to_px(sz[31:16], -norm_div(cy, cw), org[31:16]);
    end
    return r;
  endfunction

  assign pending = expected_pts.size();

  always @(posedge clk) begin
    out_beat_t e;
    if (rst) begin
      shadow_regs[REG_ROW0_01] <= RST_ROW0_01;
      shadow_regs[REG_ROW0_23] <= RST_ROW0_23;
      shadow_regs[REG_ROW1_01] <= RST_ROW1_01;
      shadow_regs[REG_ROW1_23] <= RST_ROW1_23;
      shadow_regs[REG_ROW3_01] <= RST_ROW3_01;
      shadow_regs[REG_ROW3_23] <= RST_ROW3_23;
      shadow_regs[REG_ORIGIN]  <= 64'(RST_ORIGIN);
      shadow_regs[REG_SIZE]    <= 64'(RST_SIZE);
      expected_pts.delete();
      errors <= 0;
      n_visible <= 0;
      n_hidden <= 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= REG_SIZE)
        shadow_regs[cfg_index] <= (cfg_index >= REG_ORIGIN) ? {32'd0, cfg_data[31:0]} : cfg_data;
      if (in_valid && in_ready)
        expected_pts.push_back(project(in_data));
      if (out_valid && out_ready) begin
        if (expected_pts.size() == 0) begin
          $display("%0t: unexpected output beat %h", $time, out_data);
          errors <= errors + 1;
        end else begin
          e = expected_pts.pop_front();
          if (e.visible) n_visible <= n_visible + 1;
          else n_hidden <= n_hidden + 1;
          if (e.visible !== out_data.visible || e.screen_x !== out_data.screen_x ||
              e.screen_y !== out_data.screen_y) begin
            $display("%0t: mismatch exp vis=%0d x=%h y=%h got vis=%0d x=%h y=%h", $time,
                     e.visible, e.screen_x, e.screen_y,
                     out_data.visible, out_data.screen_x, out_data.screen_y);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> verif/tb_top.sv
// Testbench top for world_to_screen_projection: clock, reset, stimulus and verdict.
// Depends on wtsp_pkg, the block and wtsp_checker.
module tb_top;
  import wtsp_pkg::*;

  localparam int DRAIN  = 60;
  localparam int WD_LIM = 5000;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  in_beat_t in_data = '0;
  out_beat_t out_data;
  int errors, pending, n_visible, n_hidden;
  int stall_left = 0, idle_cycles = 0, n_sent = 0, n_phases = 0;
  bit throttle = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  world_to_screen_projection u_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  wtsp_checker u_chk (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending, .n_visible, .n_hidden
  );

  // output side back-pressure
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (out_valid && out_ready) begin
      stall_left = throttle ? $urandom_range(0, 6) : 0;
      out_ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= (stall_left == 0);
    end else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIM) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_point(in_beat_t p);
    int gap;
    bit hs;
    gap = throttle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= p;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      hs = in_ready;
      @(posedge clk);
    end while (!hs);
    n_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    bit hs;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      hs = cfg_ready;
      @(posedge clk);
    end while (!hs);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(bit full);
    if (full) return $urandom;
    return 32'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
  endfunction

  function automatic logic [63:0] pack2(logic [31:0] lo, logic [31:0] hi);
    return {hi, lo};
  endfunction

  // random matrix; mode 0 biases the w row toward z so many points are visible
  task automatic random_setup(int mode);
    logic [31:0] c [12];
    for (int i = 0; i < 12; i++) c[i] = 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
    if (mode == 1) for (int i = 0; i < 12; i++) c[i] = $urandom;
    if (mode == 0) c[10] = $urandom_range(32'h4000, 32'h2_0000);
    write_reg(REG_ROW0_01, pack2(c[0], c[1]));
    write_reg(REG_ROW0_23, pack2(c[2], c[3]));
    write_reg(REG_ROW1_01, pack2(c[4], c[5]));
    write_reg(REG_ROW1_23, pack2(c[6], c[7]));
    write_reg(REG_ROW3_01, pack2(c[8], c[9]));
    write_reg(REG_ROW3_23, pack2(c[10], c[11]));
    write_reg(REG_ORIGIN, {$urandom, $urandom});
    write_reg(REG_SIZE, {$urandom, $urandom});
    n_phases++;
  endtask

  initial begin
    in_beat_t p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: w is constant 1.0
    send_point('{32'sd0, 32'sd0, 32'sd0});
    send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    send_point('{32'h0001_0000, 32'hFFFF_0000, 32'h0});
    drain();

    // w = z: visibility threshold, negative w, divide saturation
    write_reg(REG_ROW3_01, 64'd0);
    write_reg(REG_ROW3_23, pack2(32'h0001_0000, 32'h0));
    write_reg(REG_ORIGIN, {32'd0, 16'hFF38, 16'h0064});
    n_phases++;
    send_point('{32'h0001_0000, 32'h0001_0000, 32'sd656});
    send_point('{32'h0001_0000, 32'h0001_0000, 32'sd655});
    send_point('{32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000});
    send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'sd656});
    send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'sd700});
    send_point('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_point('{32'h0, 32'h0, 32'h8000_0000});
    drain();

    // zero-size screen, extreme origin, ignored index
    write_reg(REG_SIZE, 64'd0);
    write_reg(REG_ORIGIN, {32'd0, 16'h8000, 16'h7FFF});
    write_reg(4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(4'd15, 64'd0);
    send_point('{32'h0003_0000, 32'hFFFD_0000, 32'h0002_0000});
    send_point('{32'h8000_0000, 32'h8000_0000, 32'h0000_1000});
    drain();
    write_reg(REG_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_ORIGIN, 64'hFFFF_FFFF_FFFF_FFFF);
    send_point('{32'h0003_0000, 32'hFFFD_0000, 32'h0002_0000});
    send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0300});
    drain();

    // all-ones and all-zero matrices
    for (int k = 0; k < 2; k++) begin
      for (int r = 0; r <= 5; r++)
        write_reg(CFG_IDX_W'(r), k ? 64'd0 : 64'hFFFF_FFFF_FFFF_FFFF);
      n_phases++;
      send_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      send_point('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
      send_point('{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000});
      drain();
    end

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      random_setup(ph == 3 ? 1 : 0);
      throttle = (ph % 4 != 2);
      for (int i = 0; i < 250; i++) begin
        p.world_x = rand_coord($urandom_range(0, 3) == 0);
        p.world_y = rand_coord($urandom_range(0, 3) == 0);
        p.world_z = rand_coord($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1)) p.world_z = $urandom_range(1, 32'h7F_FFFF);
        send_point(p);
      end
      throttle = 1'b1;
      drain();
    end

    $display("Projected %0d points (%0d visible, %0d culled) over %0d register setups.",
             n_sent, n_visible, n_hidden, n_phases);
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+design
design/wtsp_pkg.sv
design/wtsp_cfg.sv
design/wtsp_clip.sv
design/wtsp_div.sv
design/wtsp_pixel.sv
design/world_to_screen_projection.sv
verif/wtsp_checker.sv
verif/tb_top.sv
